@@ rtl/core/scu_pkg.sv @@
package scu_pkg;

    // Opcodes of an input transaction (carried in tuser)
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_EVENT = 2'd2;

    // Access size codes, only long accesses act
    localparam logic [1:0] SZ_LONG = 2'd2;

    // Result kinds (carried in tuser on the output side)
    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_IRQ  = 1'b1;

    // Event sources with side effects
    localparam logic [4:0] EV_VBLANK_OUT = 5'd1;
    localparam logic [4:0] EV_HBLANK     = 5'd2;
    localparam logic [4:0] EV_TIMER0     = 5'd3;
    localparam logic [4:0] EV_EXT_FIRST  = 5'd14;
    localparam logic [4:0] EV_LIMIT      = 5'd30;

    // Mask bit shared by all external sources
    localparam logic [4:0] EXT_MASK_BIT = 5'd15;

    // Register reset values
    localparam logic [31:0] IRQ_MASK_RST = 32'h0000_BFFF;
    localparam logic [31:0] DMA_ADD_RST  = 32'h0000_0101;
    localparam logic [31:0] DMA_MODE_RST = 32'h0000_0007;

    // Register offsets
    localparam logic [7:0] A_DMA_END  = 8'h60;
    localparam logic [4:0] A_DMA_RD   = 5'h00;
    localparam logic [4:0] A_DMA_WR   = 5'h04;
    localparam logic [4:0] A_DMA_CNT  = 5'h08;
    localparam logic [4:0] A_DMA_ADD  = 5'h0C;
    localparam logic [4:0] A_DMA_EN   = 5'h10;
    localparam logic [4:0] A_DMA_MODE = 5'h14;
    localparam logic [7:0] A_MISC0    = 8'h60;
    localparam logic [7:0] A_MISC1    = 8'h7C;
    localparam logic [7:0] A_MISC2    = 8'h80;
    localparam logic [7:0] A_MISC3    = 8'h84;
    localparam logic [7:0] A_MISC4    = 8'h88;
    localparam logic [7:0] A_MISC5    = 8'h8C;
    localparam logic [7:0] A_T0_CMP   = 8'h90;
    localparam logic [7:0] A_MISC6    = 8'h94;
    localparam logic [7:0] A_MISC7    = 8'h98;
    localparam logic [7:0] A_IRQ_MASK = 8'hA0;
    localparam logic [7:0] A_IRQ_STAT = 8'hA4;
    localparam logic [7:0] A_MISC8    = 8'hA8;
    localparam logic [7:0] A_MISC9    = 8'hB0;
    localparam logic [7:0] A_MISC10   = 8'hB4;
    localparam logic [7:0] A_MISC11   = 8'hB8;
    localparam logic [7:0] A_MISC12   = 8'hC4;

    localparam int DMA_CH   = 3;
    localparam int MISC_NUM = 13;

    // One result transaction
    typedef struct packed {
        logic        kind;
        logic [31:0] data;
        logic [6:0]  vector;
        logic [3:0]  level;
        logic        last;
    } t_result;

    // Results produced by one input transaction, res0 goes out first
    typedef struct packed {
        logic [1:0] cnt;
        t_result    res1;
        t_result    res0;
    } t_res_bundle;

    // Fixed attributes of an interrupt source
    typedef struct packed {
        logic [6:0] vector;
        logic [3:0] level;
        logic [4:0] mask_idx;
        logic [4:0] stat_idx;
    } t_irq_info;

    // Level of the internal sources 0..13
    function automatic logic [3:0] int_level(input logic [4:0] ev);
        logic [3:0] lvl;
        unique case (ev)
            5'd0:    lvl = 4'hF;
            5'd1:    lvl = 4'hE;
            5'd2:    lvl = 4'hD;
            5'd3:    lvl = 4'hC;
            5'd4:    lvl = 4'hB;
            5'd5:    lvl = 4'hA;
            5'd6:    lvl = 4'h9;
            5'd7:    lvl = 4'h8;
            5'd8:    lvl = 4'h8;
            5'd9:    lvl = 4'h6;
            5'd10:   lvl = 4'h6;
            5'd11:   lvl = 4'h5;
            5'd12:   lvl = 4'h3;
            5'd13:   lvl = 4'h2;
            default: lvl = 4'h0;
        endcase
        return lvl;
    endfunction

    // Vector, level, mask bit and status bit of a source (ev < 30)
    function automatic t_irq_info irq_info(input logic [4:0] ev);
        t_irq_info info;
        if (ev < EV_EXT_FIRST) begin
            info.vector   = 7'h40 + {2'b00, ev};
            info.level    = int_level(ev);
            info.mask_idx = ev;
            info.stat_idx = ev;
        end else begin
            // external x = ev - 14: vector 0x50 + x, status bit 16 + x
            info.vector   = 7'h42 + {2'b00, ev};
            info.level    = (ev < 5'd18) ? 4'd7 : (ev < 5'd22) ? 4'd4 : 4'd1;
            info.mask_idx = EXT_MASK_BIT;
            info.stat_idx = ev + 5'd2;
        end
        return info;
    endfunction

endpackage

@@ rtl/core/scu_regs.sv @@
module scu_regs (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_fire,
    input  logic [1:0]                i_opcode,
    input  logic [1:0]                i_access_size,
    input  logic [7:0]                i_address,
    input  logic [31:0]               i_write_data,
    input  logic [4:0]                i_event_id,
    output scu_pkg::t_res_bundle      o_bundle
);

    logic [31:0] r_dma_read_addr  [scu_pkg::DMA_CH];
    logic [31:0] r_dma_write_addr [scu_pkg::DMA_CH];
    logic [31:0] r_dma_count      [scu_pkg::DMA_CH];
    logic [31:0] r_dma_add_value  [scu_pkg::DMA_CH];
    logic [31:0] r_dma_enable     [scu_pkg::DMA_CH];
    logic [31:0] r_dma_mode       [scu_pkg::DMA_CH];
    logic [31:0] r_misc           [scu_pkg::MISC_NUM];
    logic [31:0] r_irq_mask;
    logic [31:0] r_irq_status;
    logic [31:0] r_t0_cmp;
    logic [31:0] r_line_cnt;

    logic [31:0] n_irq_status;
    logic [31:0] n_line_cnt;
    logic [31:0] line_inc;
    logic [31:0] rd_val;
    logic [1:0]  dma_ch;
    logic [4:0]  dma_off;
    logic        is_long;
    logic        is_write;
    logic        is_event;
    logic        is_hblank;
    logic        t0_hit;
    logic        req_a;
    logic        req_b;
    scu_pkg::t_irq_info info_a;
    scu_pkg::t_irq_info info_b;
    scu_pkg::t_result   res_a;
    scu_pkg::t_result   res_b;

    assign dma_ch   = i_address[6:5];
    assign dma_off  = i_address[4:0];
    assign is_long  = (i_access_size == scu_pkg::SZ_LONG);
    assign is_write = (i_opcode == scu_pkg::OP_WRITE) && is_long;
    assign is_event = (i_opcode == scu_pkg::OP_EVENT) && (i_event_id < scu_pkg::EV_LIMIT);

    // Register read decode
    always_comb begin
        rd_val = '0;
        if (i_address < scu_pkg::A_DMA_END) begin
            if (dma_ch != 2'd3) begin
                priority if (dma_off == scu_pkg::A_DMA_RD) begin
                    rd_val = r_dma_read_addr[dma_ch];
                end else if (dma_off == scu_pkg::A_DMA_WR) begin
                    rd_val = r_dma_write_addr[dma_ch];
                end else if (dma_off == scu_pkg::A_DMA_CNT) begin
                    rd_val = r_dma_count[dma_ch];
                end else begin
                    rd_val = '0;
                end
            end
        end else begin
            unique case (i_address)
                scu_pkg::A_MISC1:    rd_val = r_misc[1];
                scu_pkg::A_MISC2:    rd_val = r_misc[2];
                scu_pkg::A_MISC5:    rd_val = r_misc[5];
                scu_pkg::A_IRQ_STAT: rd_val = r_irq_status;
                scu_pkg::A_MISC8:    rd_val = r_misc[8];
                scu_pkg::A_MISC12:   rd_val = r_misc[12];
                default:             rd_val = '0;
            endcase
        end
    end

    // Event decode: the source itself, then timer 0 on a line counter match
    assign info_a    = scu_pkg::irq_info(i_event_id);
    assign info_b    = scu_pkg::irq_info(scu_pkg::EV_TIMER0);
    assign is_hblank = is_event && (i_event_id == scu_pkg::EV_HBLANK);
    assign line_inc  = r_line_cnt + 32'd1;
    assign t0_hit    = is_hblank && (line_inc == r_t0_cmp);
    assign req_a     = is_event && !r_irq_mask[info_a.mask_idx];
    assign req_b     = t0_hit && !r_irq_mask[info_b.mask_idx];

    // Status and line counter next values (a status write and an event never coincide)
    always_comb begin
        n_irq_status = r_irq_status;
        if (is_write && (i_address == scu_pkg::A_IRQ_STAT)) begin
            n_irq_status = i_write_data;
        end
        if (is_event) begin
            n_irq_status[info_a.stat_idx] = 1'b1;
        end
        if (t0_hit) begin
            n_irq_status[info_b.stat_idx] = 1'b1;
        end
        n_line_cnt = r_line_cnt;
        if (is_event && (i_event_id == scu_pkg::EV_VBLANK_OUT)) begin
            n_line_cnt = '0;
        end else if (is_hblank) begin
            n_line_cnt = line_inc;
        end
    end

    // Result assembly
    always_comb begin
        res_a.kind   = scu_pkg::KIND_IRQ;
        res_a.data   = '0;
        res_a.vector = info_a.vector;
        res_a.level  = info_a.level;
        res_a.last   = !req_b;
        res_b.kind   = scu_pkg::KIND_IRQ;
        res_b.data   = '0;
        res_b.vector = info_b.vector;
        res_b.level  = info_b.level;
        res_b.last   = 1'b1;

        o_bundle.res1 = res_b;
        if (i_opcode == scu_pkg::OP_READ) begin
            o_bundle.cnt         = 2'd1;
            o_bundle.res0.kind   = scu_pkg::KIND_READ;
            o_bundle.res0.data   = is_long ? rd_val : '0;
            o_bundle.res0.vector = '0;
            o_bundle.res0.level  = '0;
            o_bundle.res0.last   = 1'b1;
        end else begin
            o_bundle.cnt  = {1'b0, req_a} + {1'b0, req_b};
            o_bundle.res0 = req_a ? res_a : res_b;
        end
    end

    // State update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < scu_pkg::DMA_CH; i++) begin
                r_dma_read_addr[i]  <= '0;
                r_dma_write_addr[i] <= '0;
                r_dma_count[i]      <= '0;
                r_dma_add_value[i]  <= scu_pkg::DMA_ADD_RST;
                r_dma_enable[i]     <= '0;
                r_dma_mode[i]       <= scu_pkg::DMA_MODE_RST;
            end
            for (int i = 0; i < scu_pkg::MISC_NUM; i++) begin
                r_misc[i] <= '0;
            end
            r_irq_mask   <= scu_pkg::IRQ_MASK_RST;
            r_irq_status <= '0;
            r_t0_cmp     <= '0;
            r_line_cnt   <= '0;
        end else if (i_fire) begin
            r_irq_status <= n_irq_status;
            r_line_cnt   <= n_line_cnt;
            if (is_write) begin
                if (i_address < scu_pkg::A_DMA_END) begin
                    if (dma_ch != 2'd3) begin
                        unique case (dma_off)
                            scu_pkg::A_DMA_RD:   r_dma_read_addr[dma_ch]  <= i_write_data;
                            scu_pkg::A_DMA_WR:   r_dma_write_addr[dma_ch] <= i_write_data;
                            scu_pkg::A_DMA_CNT:  r_dma_count[dma_ch]      <= i_write_data;
                            scu_pkg::A_DMA_ADD:  r_dma_add_value[dma_ch]  <= i_write_data;
                            scu_pkg::A_DMA_EN:   r_dma_enable[dma_ch]     <= i_write_data;
                            scu_pkg::A_DMA_MODE: r_dma_mode[dma_ch]       <= i_write_data;
                            default: ;
                        endcase
                    end
                end else begin
                    // status writes go through n_irq_status
                    unique case (i_address)
                        scu_pkg::A_MISC0:    r_misc[0]    <= i_write_data;
                        scu_pkg::A_MISC2:    r_misc[2]    <= i_write_data;
                        scu_pkg::A_MISC3:    r_misc[3]    <= i_write_data;
                        scu_pkg::A_MISC4:    r_misc[4]    <= i_write_data;
                        scu_pkg::A_MISC5:    r_misc[5]    <= i_write_data;
                        scu_pkg::A_T0_CMP:   r_t0_cmp     <= i_write_data;
                        scu_pkg::A_MISC6:    r_misc[6]    <= i_write_data;
                        scu_pkg::A_MISC7:    r_misc[7]    <= i_write_data;
                        scu_pkg::A_IRQ_MASK: r_irq_mask   <= i_write_data;
                        scu_pkg::A_MISC8:    r_misc[8]    <= i_write_data;
                        scu_pkg::A_MISC9:    r_misc[9]    <= i_write_data;
                        scu_pkg::A_MISC10:   r_misc[10]   <= i_write_data;
                        scu_pkg::A_MISC11:   r_misc[11]   <= i_write_data;
                        scu_pkg::A_MISC12:   r_misc[12]   <= i_write_data;
                        default: ;
                    endcase
                end
            end
        end
    end

endmodule

@@ rtl/core/scu_ostage.sv @@
module scu_ostage (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  scu_pkg::t_res_bundle  i_bundle,
    input  logic                  i_ready,
    output logic                  o_room,
    output logic                  o_valid,
    output scu_pkg::t_result      o_res
);

    // slot 0 drives the port, slot 1 holds the second result of an item
    logic             r_v0;
    logic             r_v1;
    scu_pkg::t_result r_slot0;
    scu_pkg::t_result r_slot1;
    logic             n_v0;
    logic             n_v1;
    logic             pop;
    logic             fill;

    assign pop     = r_v0 && i_ready;
    assign fill    = i_load && (i_bundle.cnt != 2'd0);
    assign o_room  = !r_v0 || (i_ready && !r_v1);
    assign o_valid = r_v0;
    assign o_res   = r_slot0;

    // Next valid flags; a fill only comes when slot 1 is empty and slot 0 is empty or being drained
    always_comb begin
        n_v0 = r_v0;
        n_v1 = r_v1;
        if (fill) begin
            n_v0 = 1'b1;
            n_v1 = (i_bundle.cnt == 2'd2);
        end else if (pop) begin
            if (r_v1) begin
                n_v1 = 1'b0;
            end else begin
                n_v0 = 1'b0;
            end
        end
    end

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            r_v0 <= n_v0;
            r_v1 <= n_v1;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (fill) begin
            r_slot0 <= i_bundle.res0;
            r_slot1 <= i_bundle.res1;
        end else if (pop && r_v1) begin
            r_slot0 <= r_slot1;
        end
    end

endmodule

@@ rtl/core/system_ctrl_regs_irq_unit.sv @@
// Channel   Direction  tdata                                         tuser        tlast
// s_axis    in         access_size, address, write_data, event_id   opcode       -
// m_axis    out        read_data, irq_vector, irq_level              result_kind  last
//
// One input transaction per cycle unless stalled: input register, decode and
// register update, then a two-slot result stage. A read gives one result, via
// the input register and result slot 0; an hblank event can give two in turn.
// Synchronous active-low reset returns valid flags and state registers to reset values.
// A stalled m_axis holds the result stage, and s_axis stalls once it is full.
module system_ctrl_regs_irq_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [1:0] access_size, [9:2] address, [41:10] write_data, [46:42] event_id
    input  logic [47:0] i_s_axis_tdata,
    // [1:0] opcode
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [31:0] read_data, [38:32] irq_vector, [42:39] irq_level
    output logic [47:0] o_m_axis_tdata,
    // [0] result_kind
    output logic        o_m_axis_tuser,
    output logic        o_m_axis_tlast
);

    logic                 r_in_v;
    logic [1:0]           r_opcode;
    logic [1:0]           r_access_size;
    logic [7:0]           r_address;
    logic [31:0]          r_write_data;
    logic [4:0]           r_event_id;
    logic                 room;
    logic                 fire;
    logic                 in_acc;
    scu_pkg::t_res_bundle bundle;
    scu_pkg::t_result     res;

    assign fire            = r_in_v && room;
    assign o_s_axis_tready = !r_in_v || fire;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_v <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_opcode      <= i_s_axis_tuser;
            r_access_size <= i_s_axis_tdata[1:0];
            r_address     <= i_s_axis_tdata[9:2];
            r_write_data  <= i_s_axis_tdata[41:10];
            r_event_id    <= i_s_axis_tdata[46:42];
        end
    end

    scu_regs u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (fire),
        .i_opcode      (r_opcode),
        .i_access_size (r_access_size),
        .i_address     (r_address),
        .i_write_data  (r_write_data),
        .i_event_id    (r_event_id),
        .o_bundle      (bundle)
    );

    scu_ostage u_ostage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (fire),
        .i_bundle (bundle),
        .i_ready  (i_m_axis_tready),
        .o_room   (room),
        .o_valid  (o_m_axis_tvalid),
        .o_res    (res)
    );

    // Output packing
    assign o_m_axis_tdata = {5'b00000, res.level, res.vector, res.data};
    assign o_m_axis_tuser = res.kind;
    assign o_m_axis_tlast = res.last;

endmodule

@@ bench/system_ctrl_regs_irq_unit_tb.sv @@
`timescale 1ns / 100ps

module system_ctrl_regs_irq_unit_tb;

    // Codes the package does not name
    localparam logic [1:0] OP_NONE      = 2'd3;
    localparam logic [1:0] SZ_BYTE      = 2'd0;
    localparam logic [1:0] SZ_WORD      = 2'd1;
    localparam logic [1:0] SZ_BAD       = 2'd3;
    localparam logic [4:0] EV_VBLANK_IN = 5'd0;
    localparam logic [4:0] EV_DRAW_END  = 5'd13;
    localparam logic [4:0] EV_EXT_LAST  = 5'd29;
    localparam logic [4:0] EV_MAX       = 5'd31;
    localparam logic [7:0] A_VERSION    = 8'hC8;
    localparam logic [7:0] A_TOP        = 8'hFF;

    localparam int ITEMS_PER_PHASE = 131;
    localparam int WDOG_LIMIT      = 2000;
    localparam int END_WAIT        = 16;

    // One bus operation or event as sent on s_axis
    typedef struct packed {
        logic [1:0]  op;
        logic [1:0]  sz;
        logic [7:0]  addr;
        logic [31:0] wdata;
        logic [4:0]  ev;
    } t_bus_op;

    logic        i_clk;
    logic        i_rst_n      = 1'b0;
    logic        s_tvalid     = 1'b0;
    logic [47:0] s_tdata      = '0;
    logic [1:0]  s_tuser      = '0;
    logic        m_tready     = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [47:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    // Handshake bookkeeping
    logic        s_taken      = 1'b0;
    int          src_idle_pct = 0;
    int          sink_stall_pct = 0;
    int          bad_cnt      = 0;
    int          idle_cycles  = 0;

    t_bus_op           bus_ops_q[$];
    scu_pkg::t_result  awaited_results[$];

    // Register file copy
    logic [31:0] dma_rd_m   [scu_pkg::DMA_CH];
    logic [31:0] dma_wr_m   [scu_pkg::DMA_CH];
    logic [31:0] dma_cnt_m  [scu_pkg::DMA_CH];
    logic [31:0] dma_add_m  [scu_pkg::DMA_CH];
    logic [31:0] dma_en_m   [scu_pkg::DMA_CH];
    logic [31:0] dma_mode_m [scu_pkg::DMA_CH];
    logic [31:0] misc_m     [256];
    logic [31:0] mask_m;
    logic [31:0] stat_m;
    logic [31:0] t0_cmp_m;
    logic [31:0] line_m;

    system_ctrl_regs_irq_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        // [1:0] access_size, [9:2] address, [41:10] write_data, [46:42] event_id
        .i_s_axis_tdata  (s_tdata),
        // [0+:2] opcode
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        // [31:0] read_data, [38:32] irq_vector, [42:39] irq_level
        .o_m_axis_tdata  (m_tdata),
        // [0] result_kind
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Register/interrupt predictor
    // ------------------------------------------------------------------
    function automatic void regs_reset();
        for (int c = 0; c < scu_pkg::DMA_CH; c++) begin
            dma_rd_m[c]   = '0;
            dma_wr_m[c]   = '0;
            dma_cnt_m[c]  = '0;
            dma_add_m[c]  = scu_pkg::DMA_ADD_RST;
            dma_en_m[c]   = '0;
            dma_mode_m[c] = scu_pkg::DMA_MODE_RST;
        end
        for (int a = 0; a < 256; a++) misc_m[a] = '0;
        mask_m   = scu_pkg::IRQ_MASK_RST;
        stat_m   = '0;
        t0_cmp_m = '0;
        line_m   = '0;
    endfunction

    function automatic logic [3:0] src_level(input logic [4:0] ev);
        logic [3:0] lvl;
        case (ev)
            5'd0:    lvl = 4'hF;
            5'd1:    lvl = 4'hE;
            5'd2:    lvl = 4'hD;
            5'd3:    lvl = 4'hC;
            5'd4:    lvl = 4'hB;
            5'd5:    lvl = 4'hA;
            5'd6:    lvl = 4'h9;
            5'd7,
            5'd8:    lvl = 4'h8;
            5'd9,
            5'd10:   lvl = 4'h6;
            5'd11:   lvl = 4'h5;
            5'd12:   lvl = 4'h3;
            default: lvl = 4'h2;
        endcase
        return lvl;
    endfunction

    function automatic void add_result(input logic kind, input logic [31:0] data,
                                       input logic [6:0] vec, input logic [3:0] lvl);
        scu_pkg::t_result r;
        r.kind   = kind;
        r.data   = data;
        r.vector = vec;
        r.level  = lvl;
        r.last   = 1'b0;
        awaited_results.push_back(r);
    endfunction

    function automatic logic [31:0] reg_read(input logic [7:0] a);
        logic [31:0] v;
        v = '0;
        if (a < scu_pkg::A_DMA_END) begin
            case (a[4:0])
                scu_pkg::A_DMA_RD:  v = dma_rd_m[a[6:5]];
                scu_pkg::A_DMA_WR:  v = dma_wr_m[a[6:5]];
                scu_pkg::A_DMA_CNT: v = dma_cnt_m[a[6:5]];
                default:            v = '0;
            endcase
        end else begin
            case (a)
                scu_pkg::A_MISC1, scu_pkg::A_MISC2, scu_pkg::A_MISC5,
                scu_pkg::A_MISC8, scu_pkg::A_MISC12: v = misc_m[a];
                scu_pkg::A_IRQ_STAT: v = stat_m;
                default:             v = '0;
            endcase
        end
        return v;
    endfunction

    function automatic void reg_write(input logic [7:0] a, input logic [31:0] v);
        if (a < scu_pkg::A_DMA_END) begin
            case (a[4:0])
                scu_pkg::A_DMA_RD:   dma_rd_m[a[6:5]]   = v;
                scu_pkg::A_DMA_WR:   dma_wr_m[a[6:5]]   = v;
                scu_pkg::A_DMA_CNT:  dma_cnt_m[a[6:5]]  = v;
                scu_pkg::A_DMA_ADD:  dma_add_m[a[6:5]]  = v;
                scu_pkg::A_DMA_EN:   dma_en_m[a[6:5]]   = v;
                scu_pkg::A_DMA_MODE: dma_mode_m[a[6:5]] = v;
                default: ;
            endcase
        end else begin
            case (a)
                scu_pkg::A_MISC0, scu_pkg::A_MISC2, scu_pkg::A_MISC3,
                scu_pkg::A_MISC4, scu_pkg::A_MISC5, scu_pkg::A_MISC6,
                scu_pkg::A_MISC7, scu_pkg::A_MISC8, scu_pkg::A_MISC9,
                scu_pkg::A_MISC10, scu_pkg::A_MISC11,
                scu_pkg::A_MISC12:   misc_m[a] = v;
                scu_pkg::A_T0_CMP:   t0_cmp_m  = v;
                scu_pkg::A_IRQ_MASK: mask_m    = v;
                scu_pkg::A_IRQ_STAT: stat_m    = v;
                default: ;
            endcase
        end
    endfunction

    // Status bit always set; request only when the mask bit is clear
    function automatic void raise_src(input logic [4:0] ev);
        logic [31:0] mbit;
        logic [31:0] sbit;
        logic [6:0]  vec;
        logic [3:0]  lvl;
        logic [4:0]  x;
        if (ev < scu_pkg::EV_EXT_FIRST) begin
            mbit = 32'd1 << ev;
            sbit = mbit;
            vec  = 7'h40 + {2'b00, ev};
            lvl  = src_level(ev);
        end else begin
            x    = ev - scu_pkg::EV_EXT_FIRST;
            mbit = 32'd1 << scu_pkg::EXT_MASK_BIT;
            sbit = 32'h0001_0000 << x;
            vec  = 7'h50 + {2'b00, x};
            lvl  = (x < 5'd4) ? 4'd7 : (x < 5'd8) ? 4'd4 : 4'd1;
        end
        stat_m = stat_m | sbit;
        if ((mask_m & mbit) == '0) add_result(scu_pkg::KIND_IRQ, 32'd0, vec, lvl);
    endfunction

    function automatic void scu_predict(input t_bus_op it);
        int               n0;
        scu_pkg::t_result r;
        n0 = awaited_results.size();
        case (it.op)
            scu_pkg::OP_READ:
                add_result(scu_pkg::KIND_READ,
                           (it.sz == scu_pkg::SZ_LONG) ? reg_read(it.addr) : 32'd0,
                           7'd0, 4'd0);
            scu_pkg::OP_WRITE:
                if (it.sz == scu_pkg::SZ_LONG) reg_write(it.addr, it.wdata);
            scu_pkg::OP_EVENT:
                if (it.ev < scu_pkg::EV_LIMIT) begin
                    raise_src(it.ev);
                    if (it.ev == scu_pkg::EV_VBLANK_OUT) begin
                        line_m = '0;
                    end else if (it.ev == scu_pkg::EV_HBLANK) begin
                        line_m = line_m + 32'd1;
                        if (line_m == t0_cmp_m) raise_src(scu_pkg::EV_TIMER0);
                    end
                end
            default: ;
        endcase
        // flag the final result of this transaction
        if (awaited_results.size() > n0) begin
            r      = awaited_results.pop_back();
            r.last = 1'b1;
            awaited_results.push_back(r);
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic t_bus_op mk(input logic [1:0] op, input logic [1:0] sz,
                                   input logic [7:0] addr, input logic [31:0] wdata,
                                   input logic [4:0] ev);
        t_bus_op it;
        it.op    = op;
        it.sz    = sz;
        it.addr  = addr;
        it.wdata = wdata;
        it.ev    = ev;
        return it;
    endfunction

    // Mostly DMA and misc register offsets, some fully random
    function automatic logic [7:0] rand_addr();
        int v;
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            v = 32 * $urandom_range(0, scu_pkg::DMA_CH - 1) + 4 * $urandom_range(0, 5);
        else if (pick < 8)
            v = int'(scu_pkg::A_MISC0) + 4 * $urandom_range(0, 26);
        else
            v = $urandom_range(0, 255);
        return v[7:0];
    endfunction

    function automatic t_bus_op rand_op();
        t_bus_op     it;
        logic [31:0] rnd;
        int          pick;
        int          sub;
        rnd      = $urandom;
        it.op    = scu_pkg::OP_READ;
        it.sz    = scu_pkg::SZ_LONG;
        it.addr  = rand_addr();
        it.wdata = $urandom;
        it.ev    = rnd[4:0];
        if ($urandom_range(0, 9) == 0) it.sz = rnd[6:5];
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            it.op = scu_pkg::OP_READ;
        end else if (pick < 55) begin
            it.op = scu_pkg::OP_WRITE;
            sub = $urandom_range(0, 19);
            // mask writes: mostly sparse so requests get through
            if (sub < 3) begin
                it.addr  = scu_pkg::A_IRQ_MASK;
                it.wdata = $urandom & $urandom & $urandom;
            end else if (sub < 4) begin
                it.addr = scu_pkg::A_IRQ_MASK;
            end else if (sub < 6) begin
                it.addr  = scu_pkg::A_T0_CMP;
                it.wdata = $urandom_range(0, 8);
            end
        end else if (pick < 95) begin
            it.op = scu_pkg::OP_EVENT;
            sub = $urandom_range(0, 9);
            if (sub < 4)      it.ev = scu_pkg::EV_HBLANK;
            else if (sub < 5) it.ev = scu_pkg::EV_VBLANK_OUT;
        end else begin
            it.op = OP_NONE;
        end
        return it;
    endfunction

    // Hold off until every queued transaction is out and every result is back
    task automatic drain_all();
        while (bus_ops_q.size() != 0 || s_tvalid || awaited_results.size() != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Driver: new values at the falling edge
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : drv
        t_bus_op nxt;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end else begin
            if (!s_tvalid || s_taken) begin
                if (bus_ops_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                    nxt      = bus_ops_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {1'b0, nxt.ev, nxt.wdata, nxt.addr, nxt.sz};
                    s_tuser  <= nxt.op;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on input transactions, check output transactions
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : mon
        t_bus_op          got;
        scu_pkg::t_result want;
        if (!i_rst_n) begin
            s_taken     <= 1'b0;
            idle_cycles = 0;
        end else begin
            s_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                got.sz    = s_tdata[1:0];
                got.addr  = s_tdata[9:2];
                got.wdata = s_tdata[41:10];
                got.ev    = s_tdata[46:42];
                got.op    = s_tuser;
                scu_predict(got);
            end

            if (m_tvalid && m_tready) begin
                if (awaited_results.size() == 0) begin
                    bad_cnt++;
                    if (bad_cnt <= 10)
                        $display("%0t: unexpected kind=%0d data=%h vec=%h lvl=%h last=%0d",
                                 $realtime, m_tuser, m_tdata[31:0], m_tdata[38:32],
                                 m_tdata[42:39], m_tlast);
                end else begin
                    want = awaited_results.pop_front();
                    if (m_tuser !== want.kind || m_tdata[31:0] !== want.data ||
                        m_tdata[38:32] !== want.vector || m_tdata[42:39] !== want.level ||
                        m_tlast !== want.last) begin
                        bad_cnt++;
                        if (bad_cnt <= 10) begin
                            $display("%0t: mismatch exp kind=%0d data=%h vec=%h lvl=%h last=%0d",
                                     $realtime, want.kind, want.data, want.vector,
                                     want.level, want.last);
                            $display("    got kind=%0d data=%h vec=%h lvl=%h last=%0d",
                                     m_tuser, m_tdata[31:0], m_tdata[38:32],
                                     m_tdata[42:39], m_tlast);
                        end
                    end
                end
            end

            // watchdog on cycles without any transaction
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= WDOG_LIMIT) begin
                    $display("%0t: watchdog expired", $realtime);
                    $display("Test completed with failures");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence: reset, directed checks, random phases
    // ------------------------------------------------------------------
    initial begin : seq
        t_bus_op it;
        int      n;
        regs_reset();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: masked/unmasked sources, timer-0 chain, ignored codes, extremes
        bus_ops_q.push_back(mk(scu_pkg::OP_READ,  scu_pkg::SZ_LONG, scu_pkg::A_IRQ_STAT,
                               '0, '0));
        bus_ops_q.push_back(mk(scu_pkg::OP_EVENT, scu_pkg::SZ_LONG, '0, '0, EV_VBLANK_IN));
        bus_ops_q.push_back(mk(scu_pkg::OP_READ,  scu_pkg::SZ_LONG, scu_pkg::A_IRQ_STAT,
                               '0, '0));
        bus_ops_q.push_back(mk(scu_pkg::OP_WRITE, scu_pkg::SZ_LONG, scu_pkg::A_IRQ_MASK,
                               32'h0, '0));
        bus_ops_q.push_back(mk(scu_pkg::OP_EVENT, scu_pkg::SZ_LONG, '0, '0, EV_VBLANK_IN));
        bus_ops_q.push_back(mk(scu_pkg::OP_EVENT, scu_pkg::SZ_LONG, '0, '0, EV_DRAW_END));
        bus_ops_q.push_back(mk(scu_pkg::OP_EVENT, scu_pkg::SZ_LONG, '0, '0,
                               scu_pkg::EV_EXT_FIRST));
        bus_ops_q.push_back(mk(scu_pkg::OP_EVENT, scu_pkg::SZ_LONG, '0, '0, EV_EXT_LAST));
        bus_ops_q.push_back(mk(scu_pkg::OP_WRITE, scu_pkg::SZ_LONG, scu_pkg::A_T0_CMP,
                               32'd2, '0));
        bus_ops_q.push_back(mk(scu_pkg::OP_EVENT, scu_pkg::SZ_LONG, '0, '0,
                               scu_pkg::EV_HBLANK));
        bus_ops_q.push_back(mk(scu_pkg::OP_EVENT, scu_pkg::SZ_LONG, '0, '0,
                               scu_pkg::EV_HBLANK));
        bus_ops_q.push_back(mk(scu_pkg::OP_EVENT, scu_pkg::SZ_LONG, '0, '0,
                               scu_pkg::EV_VBLANK_OUT));
        bus_ops_q.push_back(mk(scu_pkg::OP_EVENT, scu_pkg::SZ_LONG, '0, '0,
                               scu_pkg::EV_LIMIT));
        bus_ops_q.push_back(mk(scu_pkg::OP_EVENT, scu_pkg::SZ_LONG, '0, '0, EV_MAX));
        bus_ops_q.push_back(mk(OP_NONE, scu_pkg::SZ_LONG, scu_pkg::A_IRQ_STAT, '1,
                               EV_VBLANK_IN));
        bus_ops_q.push_back(mk(scu_pkg::OP_READ, SZ_BYTE, scu_pkg::A_IRQ_STAT, '0, '0));
        bus_ops_q.push_back(mk(scu_pkg::OP_READ, SZ_WORD, scu_pkg::A_IRQ_STAT, '0, '0));
        bus_ops_q.push_back(mk(scu_pkg::OP_READ, SZ_BAD,  scu_pkg::A_IRQ_STAT, '0, '0));
        bus_ops_q.push_back(mk(scu_pkg::OP_WRITE, SZ_BYTE, scu_pkg::A_MISC2, '1, '0));
        bus_ops_q.push_back(mk(scu_pkg::OP_READ,  scu_pkg::SZ_LONG, scu_pkg::A_MISC2,
                               '0, '0));
        bus_ops_q.push_back(mk(scu_pkg::OP_WRITE, scu_pkg::SZ_LONG, scu_pkg::A_MISC2,
                               '1, '0));
        bus_ops_q.push_back(mk(scu_pkg::OP_READ,  scu_pkg::SZ_LONG, scu_pkg::A_MISC2,
                               '0, '0));
        bus_ops_q.push_back(mk(scu_pkg::OP_READ,  scu_pkg::SZ_LONG,
                               scu_pkg::A_MISC2 + 8'd1, '0, '0));
        bus_ops_q.push_back(mk(scu_pkg::OP_WRITE, scu_pkg::SZ_LONG, 8'h00,
                               32'hA5C3_0F96, '0));
        bus_ops_q.push_back(mk(scu_pkg::OP_READ,  scu_pkg::SZ_LONG, 8'h00, '0, '0));
        bus_ops_q.push_back(mk(scu_pkg::OP_READ,  scu_pkg::SZ_LONG, A_VERSION, '0, '0));
        bus_ops_q.push_back(mk(scu_pkg::OP_READ,  scu_pkg::SZ_LONG, A_TOP, '0, '0));
        drain_all();

        // Random phases with different idle/stall mixes
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1:       begin src_idle_pct = 62; sink_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  sink_stall_pct = 62; end
                default: begin src_idle_pct = 24; sink_stall_pct = 24; end
            endcase
            n = 0;
            while (n < ITEMS_PER_PHASE) begin
                it = rand_op();
                bus_ops_q.push_back(it);
                n++;
            end
            drain_all();
        end

        repeat (END_WAIT) @(posedge i_clk);
        if (bad_cnt == 0 && awaited_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
